[sv/asbd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asbd_pkg
// Shared constants, codes and interface types of the audio stream buffer.
// ----------------------------------------------------------------------------
package asbd_pkg;

   // Stream buffer depth in bytes and the index width it implies.
   localparam int unsigned BUF_BYTES = 65536;
   localparam int unsigned POS_W     = $clog2(BUF_BYTES);

   // Buffer size as seen on the register bus.
   localparam logic [31:0] BUF_BYTES_W = 32'(BUF_BYTES);

   typedef logic [POS_W-1:0] pos_type;

   // Last valid read position; the read pointer wraps after it.
   localparam pos_type POS_LAST = POS_W'(BUF_BYTES - 1);

   typedef enum logic [1:0] {
      KIND_REG_READ  = 2'd0,
      KIND_REG_WRITE = 2'd1,
      KIND_BUF_WRITE = 2'd2,
      KIND_PULL      = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      BANK_FREQ     = 3'd0,
      BANK_CHANNELS = 3'd1,
      BANK_SAMPLES  = 3'd2,
      BANK_SIZE     = 3'd3,
      BANK_INIT     = 3'd4,
      BANK_COUNT    = 3'd5
   } bank_addr_type;

   // Access to the stream memory for one word.
   typedef struct packed {
      logic        rd_en;
      pos_type     rd_addr;
      logic        wr_en;
      pos_type     wr_addr;
      logic [7:0]  wr_data;
   } mem_req_type;

   // Result fields known at accept time; the sample byte follows from memory.
   typedef struct packed {
      logic [31:0] read_data;
      logic        sample_valid;
      logic        start_playback;
      logic        last;
   } rsp_meta_type;

endpackage

[sv/audio_stream_buffer_device_core.sv]
`timescale 1ns / 1ps
// Output: a word's result is registered and appears in the cycle after it is accepted.
// Throughput: one word per cycle, set by the single read and write port of the
//   stream memory; a stalled result holds the input off only while it waits.
// Reset: synchronous, active high; clears the registers, the read position,
//   the fill count and the playing flag. The stream buffer is not cleared.
// ----------------------------------------------------------------------------
// audio_stream_buffer_device_core
// Audio output device: register bank plus byte ring buffer drained by pulls.
// ----------------------------------------------------------------------------
module audio_stream_buffer_device_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [2:0]  req_bank_addr,
   input  logic [15:0] req_buf_offset,
   input  logic [31:0] req_write_data,
   input  logic        req_request_last,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_read_data,
   output logic [7:0]  rsp_sample_byte,
   output logic        rsp_sample_valid,
   output logic        rsp_start_playback,
   output logic        rsp_last
);

   logic                   accept;
   asbd_pkg::mem_req_type  mem_req;
   asbd_pkg::rsp_meta_type meta;
   logic [7:0]             mem_rd_data;

   logic                   s1_valid_ff;
   asbd_pkg::rsp_meta_type s1_meta_ff;

   // Stall the request side only while a finished word waits and is stalled;
   // otherwise the output stage empties in the same cycle it refills.
   assign req_stall = s1_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // Register bank, pointer and count; issues the memory access at accept.
   asbd_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .req_kind         (req_kind),
      .req_bank_addr    (req_bank_addr),
      .req_buf_offset   (req_buf_offset),
      .req_write_data   (req_write_data),
      .req_request_last (req_request_last),
      .mem_req          (mem_req),
      .meta             (meta)
   );

   // Stream buffer; read data is registered and held while no new read issues,
   // so it stays aligned with the output stage through a stall.
   asbd_stream_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (mem_rd_data)
   );

   // Output stage: advance whenever the downstream is not stalling it.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   // Capture result fields for the accepted word.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_meta_ff <= meta;
      end
   end

   assign rsp_valid          = s1_valid_ff;
   assign rsp_read_data      = s1_meta_ff.read_data;
   assign rsp_sample_valid   = s1_meta_ff.sample_valid;
   assign rsp_start_playback = s1_meta_ff.start_playback;
   assign rsp_last           = s1_meta_ff.last;
   // Silence reads as zero; a real sample comes from the memory read.
   assign rsp_sample_byte    = s1_meta_ff.sample_valid ? mem_rd_data : 8'd0;

`ifndef NO_ASSERTIONS
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with an empty output stage");

   a_sample_is_pull_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_sample_valid) |-> (!rsp_start_playback && rsp_read_data == '0))
      else $error("sample result carries register fields");

   a_stalled_word_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(s1_meta_ff) && $stable(rsp_sample_byte)))
      else $error("stalled result changed before it was taken");
`endif

endmodule

[sv/asbd_stream_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asbd_stream_mem
// Byte-wide stream buffer: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module asbd_stream_mem (
   input  logic                  clock,
   input  asbd_pkg::mem_req_type mem_req,
   output logic [7:0]            rd_data
);

   logic [7:0] mem_array [asbd_pkg::BUF_BYTES];
   logic [7:0] rd_data_ff;

   // Write and read; hold the read data until the next read.
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_array[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_array[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/asbd_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asbd_ctrl
// Register bank, playback pointer and fill count; issues memory accesses.
// ----------------------------------------------------------------------------
module asbd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [1:0]             req_kind,
   input  logic [2:0]             req_bank_addr,
   input  logic [15:0]            req_buf_offset,
   input  logic [31:0]            req_write_data,
   input  logic                   req_request_last,
   output asbd_pkg::mem_req_type  mem_req,
   output asbd_pkg::rsp_meta_type meta
);

   logic [31:0]       freq_ff,     freq_in;
   logic [31:0]       channels_ff, channels_in;
   logic [31:0]       samples_ff,  samples_in;
   logic [31:0]       fill_count_ff, fill_count_in;
   asbd_pkg::pos_type read_position_ff, read_position_in;
   logic              playing_ff, playing_in;

   asbd_pkg::kind_type      kind;
   asbd_pkg::bank_addr_type idx;
   logic [31:0]             cnt_clamp;
   logic                    take;
   asbd_pkg::pos_type       pos_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff          <= '0;
         channels_ff      <= '0;
         samples_ff       <= '0;
         fill_count_ff    <= '0;
         read_position_ff <= '0;
         playing_ff       <= 1'b0;
      end else begin
         freq_ff          <= freq_in;
         channels_ff      <= channels_in;
         samples_ff       <= samples_in;
         fill_count_ff    <= fill_count_in;
         read_position_ff <= read_position_in;
         playing_ff       <= playing_in;
      end
   end

   always_comb begin
      kind      = asbd_pkg::kind_type'(req_kind);
      idx       = asbd_pkg::bank_addr_type'(req_bank_addr);
      // Clamp the count to the buffer size before a pull.
      cnt_clamp = (fill_count_ff > asbd_pkg::BUF_BYTES_W) ? asbd_pkg::BUF_BYTES_W
                                                          : fill_count_ff;
      take      = playing_ff && (cnt_clamp != '0);
      pos_next  = (read_position_ff == asbd_pkg::POS_LAST) ? '0
                                                           : read_position_ff + 1'b1;

      freq_in          = freq_ff;
      channels_in      = channels_ff;
      samples_in       = samples_ff;
      fill_count_in    = fill_count_ff;
      read_position_in = read_position_ff;
      playing_in       = playing_ff;

      mem_req.rd_en   = 1'b0;
      mem_req.rd_addr = read_position_ff;
      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = asbd_pkg::POS_W'(req_buf_offset);
      mem_req.wr_data = req_write_data[7:0];

      meta = '0;

      unique case (kind) inside
         asbd_pkg::KIND_REG_READ, asbd_pkg::KIND_REG_WRITE: begin
            if (idx == asbd_pkg::BANK_INIT) begin
               meta.start_playback = 1'b1;
               if (accept) begin
                  playing_in = 1'b1;
               end
            end
            if (kind == asbd_pkg::KIND_REG_READ) begin
               unique case (idx)
                  asbd_pkg::BANK_FREQ:     meta.read_data = freq_ff;
                  asbd_pkg::BANK_CHANNELS: meta.read_data = channels_ff;
                  asbd_pkg::BANK_SAMPLES:  meta.read_data = samples_ff;
                  asbd_pkg::BANK_SIZE:     meta.read_data = asbd_pkg::BUF_BYTES_W;
                  asbd_pkg::BANK_COUNT:    meta.read_data = fill_count_ff;
                  default:                 meta.read_data = '0;
               endcase
            end else if (accept) begin
               unique case (idx)
                  asbd_pkg::BANK_FREQ:     freq_in       = req_write_data;
                  asbd_pkg::BANK_CHANNELS: channels_in   = req_write_data;
                  asbd_pkg::BANK_SAMPLES:  samples_in    = req_write_data;
                  asbd_pkg::BANK_COUNT:    fill_count_in = req_write_data;
                  default:                 ;
               endcase
            end
         end
         asbd_pkg::KIND_BUF_WRITE: begin
            // Drop writes beyond the end of the buffer.
            mem_req.wr_en = accept && (32'(req_buf_offset) < asbd_pkg::BUF_BYTES_W);
         end
         asbd_pkg::KIND_PULL: begin
            meta.last = req_request_last;
            if (playing_ff) begin
               meta.sample_valid = take;
               if (accept) begin
                  mem_req.rd_en = take;
                  fill_count_in = cnt_clamp - 32'(take);
                  if (take) begin
                     read_position_in = pos_next;
                  end
               end
            end
         end
         default: ;
      endcase
   end

`ifndef NO_ASSERTIONS
   a_read_needs_playing: assert property (@(posedge clock) disable iff (reset)
      mem_req.rd_en |-> playing_ff)
      else $error("buffer read issued while not playing");

   a_count_after_take: assert property (@(posedge clock) disable iff (reset)
      mem_req.rd_en |=> (fill_count_ff < asbd_pkg::BUF_BYTES_W))
      else $error("fill count not below buffer size after a pull");

   a_init_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && meta.start_playback) |=> playing_ff)
      else $error("init access did not start playback");
`endif

endmodule
